>>> rtl/core/velocity_pid_with_moving_stats_assert.svh
// assertion macros shared by the checker of the velocity pid block
`ifndef VELOCITY_PID_WITH_MOVING_STATS_ASSERT_SVH
`define VELOCITY_PID_WITH_MOVING_STATS_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define VPMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define VPMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/vpms_pkg.sv
// shared types, constants and helpers of the velocity pid block
`timescale 1ns / 1ps

package vpms_pkg;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 128;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // statistics window, must be a power of two
  localparam int WINDOW    = 16;
  localparam int WIN_LOG2  = $clog2(WINDOW);
  localparam int FB_SUM_W  = 32 + WIN_LOG2;
  localparam int DEV_SUM_W = 31 + WIN_LOG2;

  // result queue, power of two
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = FIFO_AW + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEGRAL_GAIN = 3'd1,
    REG_DERIV_POLE    = 3'd2,
    REG_DERIV_GAIN    = 3'd3,
    REG_SETPOINT      = 3'd4,
    REG_DRIVE_MAX     = 3'd5,
    REG_DRIVE_MIN     = 3'd6,
    REG_INVERT_ERROR  = 3'd7
  } cfg_reg_e;

  localparam logic [30:0]        RST_PROP_GAIN = 31'd65536;
  localparam logic signed [31:0] RST_DRIVE_MAX = 32'sh000A_0000;
  localparam logic signed [31:0] RST_DRIVE_MIN = 32'shFFF6_0000;

  localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;

  typedef struct packed {
    logic [30:0]        prop_gain;
    logic [30:0]        integral_gain;
    logic [15:0]        deriv_pole;
    logic [30:0]        deriv_gain;
    logic signed [31:0] setpoint;
    logic signed [31:0] drive_max;
    logic signed [31:0] drive_min;
    logic               invert_error;
  } cfg_t;

  // error differences and feedback statistics
  typedef struct packed {
    logic signed [32:0] err;
    logic signed [33:0] diff1;
    logic signed [34:0] diff2;
    logic signed [32:0] dev_diff;
    logic signed [31:0] fb_mean;
  } b_t;

  // rounded gain products
  typedef struct packed {
    logic signed [50:0] p;
    logic signed [51:0] dd;
    logic signed [31:0] integ;
    logic [30:0]        dev;
    logic signed [31:0] fb_mean;
  } d_t;

  // clamped drive with statistics riding along
  typedef struct packed {
    logic signed [31:0] drive;
    logic [30:0]        dev;
    logic signed [31:0] fb_mean;
  } g_t;

  // result word, last field in the lowest bits
  typedef struct packed {
    logic               pad;
    logic signed [31:0] drive_mean;
    logic [30:0]        feedback_variance;
    logic signed [31:0] feedback_mean;
    logic signed [31:0] drive;
  } out_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/vpms_front.sv
// error forming, error history and feedback window statistics
`timescale 1ns / 1ps

module vpms_front import vpms_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               valid_i,
  input  logic signed [31:0] fb_i,
  output logic               valid_o,
  output b_t                 data_o
);

  logic signed [32:0]          err_raw, err;
  logic signed [33:0]          diff1;
  logic signed [34:0]          diff2;
  logic signed [32:0]          dev_diff;
  logic signed [FB_SUM_W-1:0]  fb_sum_d;
  logic signed [31:0]          fb_mean_d;

  logic signed [32:0]          last_err_q, prev_err_q;
  logic signed [FB_SUM_W-1:0]  fb_sum_q;
  logic signed [31:0]          fb_mean_q;
  logic signed [31:0]          fb_win_q [WINDOW];
  logic                        valid_q;
  b_t                          data_q;

  always_comb begin
    err_raw  = 33'($signed(cfg_i.setpoint)) - 33'(fb_i);
    err      = cfg_i.invert_error ? -err_raw : err_raw;
    diff1    = 34'(err) - 34'(last_err_q);
    diff2    = 35'(err) - (35'(last_err_q) <<< 1) + 35'(prev_err_q);
    // deviation about the mean held before this sample
    dev_diff = 33'(fb_i) - 33'(fb_mean_q);
    fb_sum_d = fb_sum_q + FB_SUM_W'(fb_i) - FB_SUM_W'(fb_win_q[WINDOW-1]);
    fb_mean_d = fb_sum_d[FB_SUM_W-1:WIN_LOG2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      last_err_q <= '0;
      prev_err_q <= '0;
      fb_sum_q   <= '0;
      fb_mean_q  <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        fb_win_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_i;
      if (valid_i) begin
        prev_err_q  <= last_err_q;
        last_err_q  <= err;
        fb_sum_q    <= fb_sum_d;
        fb_mean_q   <= fb_mean_d;
        fb_win_q[0] <= fb_i;
        for (int i = 1; i < WINDOW; i++) begin
          fb_win_q[i] <= fb_win_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      data_q.err      <= err;
      data_q.diff1    <= diff1;
      data_q.diff2    <= diff2;
      data_q.dev_diff <= dev_diff;
      data_q.fb_mean  <= fb_mean_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/core/vpms_gain.sv
// split gain products, rounding to q16.16 and squared deviation
`timescale 1ns / 1ps

module vpms_gain import vpms_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic valid_i,
  input  b_t   data_i,
  output logic valid_o,
  output d_t   data_o
);

  typedef struct packed {
    logic [46:0]        p_lo;
    logic signed [49:0] p_hi;
    logic [46:0]        d_lo;
    logic signed [50:0] d_hi;
    logic [46:0]        i_lo;
    logic signed [48:0] i_hi;
    logic [47:0]        sq;
    logic               dev_big;
    logic signed [31:0] fb_mean;
  } c_t;

  // (x + 2^15) >> 16 on the low partial product
  function automatic logic [31:0] round_lo(input logic [46:0] x);
    logic [47:0] s;
    s = {1'b0, x} + 48'h8000;
    return s[47:16];
  endfunction

  c_t                 c_d, c_q;
  d_t                 d_d, d_q;
  logic               c_valid_q, d_valid_q;
  logic [32:0]        mag;
  logic signed [49:0] i_full;
  logic [32:0]        sq_r;
  logic [48:0]        sq_s;

  // partial products: value = hi * 2^16 + lo, lo unsigned 16 bits
  always_comb begin
    mag       = data_i.dev_diff[32] ? (33'd0 - data_i.dev_diff) : data_i.dev_diff;
    c_d.p_lo  = 47'(cfg_i.prop_gain) * 47'(data_i.diff1[15:0]);
    c_d.p_hi  = 50'($signed({1'b0, cfg_i.prop_gain})) * 50'($signed(data_i.diff1[33:16]));
    c_d.d_lo  = 47'(cfg_i.deriv_gain) * 47'(data_i.diff2[15:0]);
    c_d.d_hi  = 51'($signed({1'b0, cfg_i.deriv_gain})) * 51'($signed(data_i.diff2[34:16]));
    c_d.i_lo  = 47'(cfg_i.integral_gain) * 47'(data_i.err[15:0]);
    c_d.i_hi  = 49'($signed({1'b0, cfg_i.integral_gain})) * 49'($signed(data_i.err[32:16]));
    c_d.sq    = 48'(mag[23:0]) * 48'(mag[23:0]);
    c_d.dev_big = |mag[32:24];
    c_d.fb_mean = data_i.fb_mean;
  end

  always_comb begin
    d_d.p    = 51'(c_q.p_hi) + 51'($signed({1'b0, round_lo(c_q.p_lo)}));
    d_d.dd   = 52'(c_q.d_hi) + 52'($signed({1'b0, round_lo(c_q.d_lo)}));
    i_full   = 50'(c_q.i_hi) + 50'($signed({1'b0, round_lo(c_q.i_lo)}));
    d_d.integ = sat32(64'(i_full));
    sq_s     = {1'b0, c_q.sq} + 49'h8000;
    sq_r     = sq_s[48:16];
    d_d.dev  = (c_q.dev_big || (|sq_r[32:31])) ? 31'h7FFF_FFFF : sq_r[30:0];
    d_d.fb_mean = c_q.fb_mean;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      c_valid_q <= valid_i;
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      c_q <= c_d;
    end
    if (c_valid_q) begin
      d_q <= d_d;
    end
  end

  assign valid_o = d_valid_q;
  assign data_o  = d_q;

endmodule

>>> rtl/core/vpms_ctrl.sv
// derivative filter, delayed integral and clamped drive recurrences
`timescale 1ns / 1ps

module vpms_ctrl import vpms_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic valid_i,
  input  d_t   data_i,
  output logic valid_o,
  output g_t   data_o
);

  typedef struct packed {
    logic signed [51:0] pi;
    logic signed [31:0] dterm;
    logic [30:0]        dev;
    logic signed [31:0] fb_mean;
  } e_t;

  typedef struct packed {
    logic signed [52:0] x;
    logic [30:0]        dev;
    logic signed [31:0] fb_mean;
  } f_t;

  e_t                 e_d, e_q;
  f_t                 f_d, f_q;
  logic               e_valid_q, f_valid_q, g_valid_q;
  logic signed [31:0] ldt_q, integ_q, last_drive_q;
  logic [30:0]        g_dev_q;
  logic signed [31:0] g_mean_q;

  logic signed [48:0] pole_prod, pole_sum;
  logic signed [52:0] d_full;
  logic signed [53:0] v, v_hi, max_x, min_x;
  logic               over_max, under_min;
  logic signed [31:0] drive_d;

  // derivative loop: one 16x32 product per item
  always_comb begin
    pole_prod = 49'($signed({1'b0, cfg_i.deriv_pole})) * 49'(ldt_q);
    pole_sum  = pole_prod + 49'sh8000;
    d_full    = 53'($signed(pole_sum[48:16])) - 53'(data_i.dd);
    e_d.dterm = sat32(64'(d_full));
    // integral term is the one formed from the previous error
    e_d.pi      = 52'(data_i.p) + 52'(integ_q);
    e_d.dev     = data_i.dev;
    e_d.fb_mean = data_i.fb_mean;
  end

  always_comb begin
    f_d.x       = 53'(e_q.pi) + 53'(e_q.dterm);
    f_d.dev     = e_q.dev;
    f_d.fb_mean = e_q.fb_mean;
  end

  // drive loop: add to last drive, clip high first, then low
  always_comb begin
    v         = 54'(last_drive_q) + 54'(f_q.x);
    max_x     = 54'($signed(cfg_i.drive_max));
    min_x     = 54'($signed(cfg_i.drive_min));
    over_max  = v > max_x;
    v_hi      = over_max ? max_x : v;
    under_min = v_hi < min_x;
    drive_d   = under_min ? $signed(cfg_i.drive_min) : v_hi[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q    <= 1'b0;
      f_valid_q    <= 1'b0;
      g_valid_q    <= 1'b0;
      ldt_q        <= '0;
      integ_q      <= '0;
      last_drive_q <= '0;
    end else begin
      e_valid_q <= valid_i;
      f_valid_q <= e_valid_q;
      g_valid_q <= f_valid_q;
      if (valid_i) begin
        ldt_q   <= e_d.dterm;
        integ_q <= data_i.integ;
      end
      if (f_valid_q) begin
        last_drive_q <= drive_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      e_q <= e_d;
    end
    if (e_valid_q) begin
      f_q <= f_d;
    end
    if (f_valid_q) begin
      g_dev_q  <= f_q.dev;
      g_mean_q <= f_q.fb_mean;
    end
  end

  assign valid_o        = g_valid_q;
  assign data_o.drive   = last_drive_q;
  assign data_o.dev     = g_dev_q;
  assign data_o.fb_mean = g_mean_q;

endmodule

>>> rtl/core/vpms_stats.sv
// deviation and drive windows, result queue and input credit count
`timescale 1ns / 1ps

module vpms_stats import vpms_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  g_t   data_i,
  input  logic accept_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  logic [DEV_SUM_W-1:0]       dev_sum_q, dev_sum_d;
  logic signed [FB_SUM_W-1:0] drv_sum_q, drv_sum_d;
  logic [30:0]                dev_win_q [WINDOW];
  logic signed [31:0]         drv_win_q [WINDOW];

  out_t                       res;
  out_t                       fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]         wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]           cnt_q, occ_q;
  logic                       pop;

  always_comb begin
    dev_sum_d = dev_sum_q + DEV_SUM_W'(data_i.dev) - DEV_SUM_W'(dev_win_q[WINDOW-1]);
    drv_sum_d = drv_sum_q + FB_SUM_W'(data_i.drive) - FB_SUM_W'(drv_win_q[WINDOW-1]);
    res.pad               = 1'b0;
    res.drive             = data_i.drive;
    res.feedback_mean     = data_i.fb_mean;
    res.feedback_variance = dev_sum_d[DEV_SUM_W-1:WIN_LOG2];
    res.drive_mean        = drv_sum_d[FB_SUM_W-1:WIN_LOG2];
  end

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != '0;
  assign out_o       = fifo_q[rd_ptr_q];
  // every accepted item owns a queue slot until it is delivered
  assign in_ready_o  = occ_q != CNT_W'(FIFO_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_sum_q <= '0;
      drv_sum_q <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        dev_win_q[i] <= '0;
        drv_win_q[i] <= '0;
      end
    end else if (valid_i) begin
      dev_sum_q    <= dev_sum_d;
      drv_sum_q    <= drv_sum_d;
      dev_win_q[0] <= data_i.dev;
      drv_win_q[0] <= data_i.drive;
      for (int i = 1; i < WINDOW; i++) begin
        dev_win_q[i] <= dev_win_q[i-1];
        drv_win_q[i] <= drv_win_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      occ_q    <= '0;
    end else begin
      if (valid_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({valid_i, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
      unique case ({accept_i, pop})
        2'b10:   occ_q <= occ_q + 1'b1;
        2'b01:   occ_q <= occ_q - 1'b1;
        default: occ_q <= occ_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

endmodule

>>> rtl/core/velocity_pid_with_moving_stats.sv
// top level of the velocity-form pid controller with sliding statistics
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  feedback
//  m_axis    out  m_axis_tvalid / m_axis_tready  drive, means, variance
//  cfg       in   cfg_we_i                       register index and value
//
// one transaction per clock cycle sustained while the output side keeps up; a
// result passes from the input register through the front stage, two gain
// stages, three control stages, then the result queue
// the drive and derivative recurrences each close within a single stage
// reset clears all history and windows at once; no clearing pass is needed
// s_axis_tready drops only when sixteen transactions are outstanding, which
// takes a stalled output side; the pipeline itself never stops
`timescale 1ns / 1ps

module velocity_pid_with_moving_stats import vpms_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // feedback [31:0]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // drive [31:0], feedback_mean [63:32], feedback_variance [94:64],
  // drive_mean [126:95], zero [127]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  cfg_t               cfg_q;
  logic               accept;
  logic               a_valid_q;
  logic signed [31:0] a_fb_q;

  logic               b_valid, d_valid, g_valid;
  b_t                 b_data;
  d_t                 d_data;
  g_t                 g_data;
  out_t               res;

  assign accept = s_axis_tvalid && s_axis_tready;

  // register file, bits above each register width are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain     <= RST_PROP_GAIN;
      cfg_q.integral_gain <= '0;
      cfg_q.deriv_pole    <= '0;
      cfg_q.deriv_gain    <= '0;
      cfg_q.setpoint      <= '0;
      cfg_q.drive_max     <= RST_DRIVE_MAX;
      cfg_q.drive_min     <= RST_DRIVE_MIN;
      cfg_q.invert_error  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PROP_GAIN:     cfg_q.prop_gain     <= cfg_wdata_i[30:0];
        REG_INTEGRAL_GAIN: cfg_q.integral_gain <= cfg_wdata_i[30:0];
        REG_DERIV_POLE:    cfg_q.deriv_pole    <= cfg_wdata_i[15:0];
        REG_DERIV_GAIN:    cfg_q.deriv_gain    <= cfg_wdata_i[30:0];
        REG_SETPOINT:      cfg_q.setpoint      <= $signed(cfg_wdata_i);
        REG_DRIVE_MAX:     cfg_q.drive_max     <= $signed(cfg_wdata_i);
        REG_DRIVE_MIN:     cfg_q.drive_min     <= $signed(cfg_wdata_i);
        REG_INVERT_ERROR:  cfg_q.invert_error  <= cfg_wdata_i[0];
        default:           cfg_q               <= cfg_q;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_fb_q <= $signed(s_axis_tdata[31:0]);
    end
  end

  // error, error history and feedback mean
  vpms_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (a_valid_q),
    .fb_i    (a_fb_q),
    .valid_o (b_valid),
    .data_o  (b_data)
  );

  // gain products in two halves, then rounded and summed
  vpms_gain u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (b_valid),
    .data_i  (b_data),
    .valid_o (d_valid),
    .data_o  (d_data)
  );

  // filtered derivative, integral delay and drive clamp
  vpms_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (d_valid),
    .data_i  (d_data),
    .valid_o (g_valid),
    .data_o  (g_data)
  );

  // variance and drive means, result queue, input credit
  vpms_stats u_stats (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (g_valid),
    .data_i      (g_data),
    .accept_i    (accept),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = res;

endmodule

>>> rtl/core/vpms_chk.sv
// port-level checker of the velocity pid block and its bind
`timescale 1ns / 1ps

`include "velocity_pid_with_moving_stats_assert.svh"

module vpms_chk import vpms_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // a stalled result holds
  `VPMS_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // with nothing queued for output the block never holds off input
  `VPMS_ASSERT_IMP(a_ready_when_drained, !m_axis_tvalid, s_axis_tready, "input held off while output queue empty")

  // a result appearing on an empty output came from an earlier input transaction
  `VPMS_ASSERT_IMP(a_result_latency, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 8), "result without matching input transaction")

  // padding bit of the result word stays zero
  `VPMS_ASSERT_IMP(a_pad_zero, m_axis_tvalid, !m_axis_tdata[OUT_TDATA_W-1], "nonzero padding in result")

endmodule

bind velocity_pid_with_moving_stats vpms_chk u_vpms_chk (.*);
